// ----- rtl/bpsr_pkg.sv -----
package bpsr_pkg;

  localparam int unsigned PATTERN_BYTES_DEF = 8;
  localparam int unsigned OFFSET_BITS_DEF   = 32;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_PATTERN  = 3'd0,
    REG_SEARCH_LENGTH   = 3'd1,
    REG_REPLACE_PATTERN = 3'd2,
    REG_REPLACE_LENGTH  = 3'd3,
    REG_MATCH_LIMIT     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] search_pattern;
    logic [3:0]  search_length;
    logic [63:0] replace_pattern;
    logic [3:0]  replace_length;
    logic [15:0] match_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        end_of_stream;
    logic [31:0] last_match_offset;
    logic [15:0] match_count;
  } out_t;

  // byte i of a 64-bit pattern, zero beyond the eighth
  function automatic logic [7:0] pat_byte(logic [63:0] pat, int unsigned i);
    logic [7:0] b;
    b = 8'h00;
    if (i < 8) begin
      b = pat[i*8 +: 8];
    end
    return b;
  endfunction

endpackage

// ----- rtl/bpsr_cfg.sv -----
module bpsr_cfg
  import bpsr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SEARCH_PATTERN:  cfg_d.search_pattern  = cfg_data_i;
        REG_SEARCH_LENGTH:   cfg_d.search_length   = cfg_data_i[3:0];
        REG_REPLACE_PATTERN: cfg_d.replace_pattern = cfg_data_i;
        REG_REPLACE_LENGTH:  cfg_d.replace_length  = cfg_data_i[3:0];
        REG_MATCH_LIMIT:     cfg_d.match_limit     = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.search_pattern  <= '0;
      cfg_q.search_length   <= 4'd1;
      cfg_q.replace_pattern <= '0;
      cfg_q.replace_length  <= '0;
      cfg_q.match_limit     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/bpsr_step.sv -----
// One window position: test head, patch in place, pop head, shift.
module bpsr_step
  import bpsr_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF,
  localparam int unsigned LW           = $clog2(PATTERN_BYTES + 1)
) (
  input  cfg_t                   cfg_i,
  input  logic [7:0]             win_i [PATTERN_BYTES],
  input  logic [LW-1:0]          fill_i,
  input  logic [15:0]            hits_i,
  input  logic [31:0]            latest_i,
  input  logic [OFFSET_BITS-1:0] head_i,
  output logic [7:0]             win_o [PATTERN_BYTES],
  output logic [LW-1:0]          fill_o,
  output logic [15:0]            hits_o,
  output logic [31:0]            latest_o,
  output logic [OFFSET_BITS-1:0] head_o,
  output logic [7:0]             byte_o
);

  localparam logic [7:0] PB = 8'(PATTERN_BYTES);

  logic [7:0]              s8, r8, sl8, rl8, fill8;
  logic                    allowed, same, hit;
  logic [7:0]              patched [PATTERN_BYTES];
  logic [OFFSET_BITS+31:0] head_ext;

  always_comb begin
    s8    = {4'b0, cfg_i.search_length};
    r8    = {4'b0, cfg_i.replace_length};
    fill8 = 8'(fill_i);
    // search length zero counts as one; both lengths clip at window size
    if (s8 == 8'd0)    sl8 = 8'd1;
    else if (s8 > PB)  sl8 = PB;
    else               sl8 = s8;
    rl8 = (r8 > PB) ? PB : r8;

    allowed = (cfg_i.match_limit == 16'd0) || (hits_i < cfg_i.match_limit);
    same = 1'b1;
    for (int unsigned i = 0; i < PATTERN_BYTES; i++) begin
      if ((8'(i) < sl8) && (win_i[i] != pat_byte(cfg_i.search_pattern, i))) begin
        same = 1'b0;
      end
    end
    hit = allowed && (fill8 >= sl8) && same;

    for (int unsigned i = 0; i < PATTERN_BYTES; i++) begin
      patched[i] = win_i[i];
      if (hit && (8'(i) < rl8) && (8'(i) < fill8)) begin
        patched[i] = pat_byte(cfg_i.replace_pattern, i);
      end
    end

    for (int unsigned i = 0; i + 1 < PATTERN_BYTES; i++) begin
      win_o[i] = patched[i+1];
    end
    win_o[PATTERN_BYTES-1] = 8'h00;
  end

  assign head_ext = {32'b0, head_i};
  assign byte_o   = patched[0];
  assign hits_o   = (hit && (hits_i != 16'hFFFF)) ? hits_i + 16'd1 : hits_i;
  assign latest_o = hit ? head_ext[31:0] : latest_i;
  assign fill_o   = (fill_i != '0) ? fill_i - LW'(1) : fill_i;
  assign head_o   = head_i + OFFSET_BITS'(1);

endmodule

// ----- rtl/byte_pattern_search_replace.sv -----
// Streaming byte search and replace. Bytes enter on the in channel, one
// beat each, and pass through a window of PATTERN_BYTES bytes; once the
// window is full every new beat pushes the oldest byte out, after it has
// been tested as the start of a match against the first search_length
// pattern bytes and, on a hit, overwritten in place with replace_length
// replacement bytes (later positions see the patched data). One byte is taken
// per unstalled cycle and the first result appears after PATTERN_BYTES beats.
// The beat marked last_byte drains the window: it produces one result per
// byte still held (up to PATTERN_BYTES), issued one per unstalled cycle from
// the single compare/patch step, and the in channel stalls until the drain is
// done. Each result carries the running hit count and last hit offset; the
// end_of_stream beat holds the final values, after which the stream state
// clears for the next buffer. Configuration is to be written only while no
// buffer is in flight; a write takes effect from the next cycle.
module byte_pattern_search_replace
  import bpsr_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  localparam int unsigned LW = $clog2(PATTERN_BYTES + 1);

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  cfg_t cfg;

  state_e                 state_q, state_d;
  logic [7:0]             win_q [PATTERN_BYTES];
  logic [7:0]             win_d [PATTERN_BYTES];
  logic [LW-1:0]          fill_q, fill_d;
  logic [OFFSET_BITS-1:0] head_q, head_d;
  logic [15:0]            hits_q, hits_d;
  logic [31:0]            latest_q, latest_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  // window with the incoming byte appended
  logic [7:0]             win_app [PATTERN_BYTES];
  logic [LW-1:0]          fill_app;

  // step unit operands and results
  logic [7:0]             st_win [PATTERN_BYTES];
  logic [LW-1:0]          st_fill;
  logic [7:0]             nx_win [PATTERN_BYTES];
  logic [LW-1:0]          nx_fill;
  logic [15:0]            nx_hits;
  logic [31:0]            nx_latest;
  logic [OFFSET_BITS-1:0] nx_head;
  logic [7:0]             nx_byte;

  logic out_free, accept, do_emit, is_final, flushing;

  bpsr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // output register can take a beat this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign flushing   = (state_q == ST_FLUSH);
  assign in_stall_o = flushing || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    for (int unsigned i = 0; i < PATTERN_BYTES; i++) begin
      win_app[i] = (LW'(i) == fill_q) ? in_data_i.data_byte : win_q[i];
    end
  end
  assign fill_app = fill_q + LW'(1);

  // during the drain the step works on the stored window
  always_comb begin
    for (int unsigned i = 0; i < PATTERN_BYTES; i++) begin
      st_win[i] = flushing ? win_q[i] : win_app[i];
    end
  end
  assign st_fill = flushing ? fill_q : fill_app;

  bpsr_step #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_step (
    .cfg_i    (cfg),
    .win_i    (st_win),
    .fill_i   (st_fill),
    .hits_i   (hits_q),
    .latest_i (latest_q),
    .head_i   (head_q),
    .win_o    (nx_win),
    .fill_o   (nx_fill),
    .hits_o   (nx_hits),
    .latest_o (nx_latest),
    .head_o   (nx_head),
    .byte_o   (nx_byte)
  );

  // a byte leaves as the window fills, on the last beat, or per free drain cycle
  assign do_emit = flushing ? out_free
                 : (accept && (in_data_i.last_byte || (fill_app == LW'(PATTERN_BYTES))));
  // final byte: the one left alone in the window once the buffer has ended
  assign is_final = (flushing || in_data_i.last_byte) && (st_fill == LW'(1));

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    fill_d      = fill_q;
    head_d      = head_q;
    hits_d      = hits_q;
    latest_d    = latest_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (do_emit) begin
      out_valid_d             = 1'b1;
      out_d.out_byte          = nx_byte;
      out_d.end_of_stream     = is_final;
      out_d.last_match_offset = nx_latest;
      out_d.match_count       = nx_hits;
      if (is_final) begin
        // buffer done: stream state back to reset
        state_d  = ST_FILL;
        for (int unsigned i = 0; i < PATTERN_BYTES; i++) begin
          win_d[i] = 8'h00;
        end
        fill_d   = '0;
        head_d   = '0;
        hits_d   = '0;
        latest_d = '0;
      end else begin
        if (!flushing && in_data_i.last_byte) begin
          state_d = ST_FLUSH;
        end
        win_d    = nx_win;
        fill_d   = nx_fill;
        head_d   = nx_head;
        hits_d   = nx_hits;
        latest_d = nx_latest;
      end
    end else if (accept) begin
      win_d  = win_app;
      fill_d = fill_app;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      for (int unsigned i = 0; i < PATTERN_BYTES; i++) begin
        win_q[i] <= 8'h00;
      end
      fill_q      <= '0;
      head_q      <= '0;
      hits_q      <= '0;
      latest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      hits_q      <= hits_d;
      latest_q    <= latest_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- bench/bpsr_checker.sv -----
module bpsr_checker
  import bpsr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_o,
  input  in_t                   in_data_i,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  out_t                  out_data_o,
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WB = PATTERN_BYTES_DEF;

  // register shadow
  logic [63:0] srch_pat;
  logic [3:0]  srch_len;
  logic [63:0] repl_pat;
  logic [3:0]  repl_len;
  logic [15:0] hit_limit;

  // stream state
  logic [7:0]  win_byte [WB];
  int unsigned win_fill;
  logic [31:0] head_pos;
  logic [15:0] hit_cnt;
  logic [31:0] hit_off;

  out_t patched_q [$];

  function automatic logic [7:0] byte_of(logic [63:0] pat, int unsigned i);
    logic [63:0] sh;
    sh = pat >> (8 * (i & 7));
    return (i < 8) ? sh[7:0] : 8'h00;
  endfunction

  function automatic int unsigned clip_len(logic [3:0] v, int unsigned lo);
    int unsigned w;
    w = 32'(v);
    if (w < lo) return lo;
    if (w > WB) return WB;
    return w;
  endfunction

  task automatic clear_stream();
    for (int unsigned i = 0; i < WB; i++) win_byte[i] = 8'h00;
    win_fill = 0;
    head_pos = '0;
    hit_cnt  = '0;
    hit_off  = '0;
  endtask

  // test the head position, patch on a hit, queue the head byte, shift
  task automatic patch_head(input logic fin);
    int unsigned sl;
    int unsigned rl;
    bit          same;
    out_t        res;
    sl = clip_len(srch_len, 1);
    rl = clip_len(repl_len, 0);
    if ((hit_limit == 16'd0 || hit_cnt < hit_limit) && win_fill >= sl) begin
      same = 1'b1;
      for (int unsigned i = 0; i < sl; i++) begin
        if (win_byte[i] != byte_of(srch_pat, i)) same = 1'b0;
      end
      if (same) begin
        if (hit_cnt != 16'hFFFF) hit_cnt++;
        hit_off = head_pos;
        for (int unsigned i = 0; i < rl && i < win_fill; i++) begin
          win_byte[i] = byte_of(repl_pat, i);
        end
      end
    end
    res.out_byte          = win_byte[0];
    res.end_of_stream     = fin;
    res.last_match_offset = hit_off;
    res.match_count       = hit_cnt;
    patched_q.push_back(res);
    for (int unsigned i = 1; i < win_fill; i++) win_byte[i-1] = win_byte[i];
    win_byte[WB-1] = 8'h00;
    if (win_fill > 0) win_fill--;
    head_pos++;
  endtask

  task automatic absorb_byte(input in_t beat);
    if (win_fill < WB) begin
      win_byte[win_fill] = beat.data_byte;
      win_fill++;
    end
    if (beat.last_byte) begin
      while (win_fill > 0) patch_head(win_fill == 1);
      clear_stream();
    end else if (win_fill >= WB) begin
      patch_head(1'b0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      srch_pat  = '0;
      srch_len  = 4'd1;
      repl_pat  = '0;
      repl_len  = 4'd0;
      hit_limit = '0;
      clear_stream();
      patched_q.delete();
      errors_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEARCH_PATTERN:  srch_pat  = cfg_data_i;
          REG_SEARCH_LENGTH:   srch_len  = cfg_data_i[3:0];
          REG_REPLACE_PATTERN: repl_pat  = cfg_data_i;
          REG_REPLACE_LENGTH:  repl_len  = cfg_data_i[3:0];
          REG_MATCH_LIMIT:     hit_limit = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) absorb_byte(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (patched_q.size() == 0) begin
          $error("unexpected output beat %h", out_data_o);
          errors_o++;
        end else begin
          want = patched_q.pop_front();
          if (out_data_o.out_byte !== want.out_byte) begin
            $error("out_byte exp %h got %h", want.out_byte, out_data_o.out_byte);
            errors_o++;
          end
          if (out_data_o.end_of_stream !== want.end_of_stream) begin
            $error("end_of_stream exp %b got %b", want.end_of_stream,
                   out_data_o.end_of_stream);
            errors_o++;
          end
          if (out_data_o.last_match_offset !== want.last_match_offset) begin
            $error("last_match_offset exp %h got %h", want.last_match_offset,
                   out_data_o.last_match_offset);
            errors_o++;
          end
          if (out_data_o.match_count !== want.match_count) begin
            $error("match_count exp %h got %h", want.match_count,
                   out_data_o.match_count);
            errors_o++;
          end
        end
      end
    end
    pending_o = patched_q.size();
  end

endmodule

// ----- bench/tb_byte_pattern_search_replace.sv -----
module tb_byte_pattern_search_replace;
  import bpsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WB          = PATTERN_BYTES_DEF;
  localparam int unsigned QUIET_LIMIT = 4000;  // cycles with no beat on either side
  localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int unsigned RAND_ITEMS  = 260;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_SEARCH_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  in_t                   in_data_i   = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_t                  out_data_o;

  int err_cnt;
  int pending;

  // stimulus-side knowledge of the pattern, used to build matching streams
  logic [63:0] cur_sp;
  int unsigned cur_sl;
  int unsigned run_k;
  int unsigned burst_left;
  int unsigned rand_items;
  logic        pressure_go = 1'b0;
  int unsigned quiet;

  byte_pattern_search_replace DUT (.*);

  bpsr_checker u_check (.*, .errors_o(err_cnt), .pending_o(pending));

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: any beat on either channel resets the quiet count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: stretches of random length, each with its own stall density.
  // Once pressure_go rises it holds off for HOLD_CYCLES so the window fills
  // and the block has to stall its input.
  initial begin : receiver
    int unsigned stretch;
    int unsigned level;
    int unsigned held;
    stretch = 0;
    level   = 0;
    held    = 0;
    forever begin
      @(negedge clk_i);
      if (pressure_go && held < HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
        held++;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(4, 60);
          level   = $urandom_range(0, 3);
        end
        stretch--;
        case (level)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Called at a falling edge; leaves the write enable high for the next edge.
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  // All five registers; junk puts random bits above the used field.
  task automatic apply_cfg(input logic [63:0] sp, input logic [3:0] sl,
                           input logic [63:0] rp, input logic [3:0] rl,
                           input logic [15:0] ml, input bit junk);
    logic [63:0] hi;
    hi = junk ? {$urandom, $urandom} : 64'd0;
    write_reg(REG_SEARCH_PATTERN, sp);
    write_reg(REG_SEARCH_LENGTH, {hi[63:4], sl});
    write_reg(REG_REPLACE_PATTERN, rp);
    write_reg(REG_REPLACE_LENGTH, {hi[63:4], rl});
    write_reg(REG_MATCH_LIMIT, {hi[63:16], ml});
    cfg_we_i <= 1'b0;
    cur_sp = sp;
    cur_sl = (sl == 0) ? 1 : ((sl > WB) ? WB : sl);
  endtask

  task automatic rand_cfg();
    logic [3:0]  sl;
    logic [3:0]  rl;
    logic [15:0] ml;
    sl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                     : 4'($urandom_range(1, 4));
    rl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                     : 4'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      6, 7:    ml = 16'($urandom_range(1, 3));
      8:       ml = 16'($urandom);
      9:       ml = 16'hFFFF;
      default: ml = 16'd0;
    endcase
    apply_cfg({$urandom, $urandom}, sl, {$urandom, $urandom}, rl, ml,
              1'($urandom_range(0, 1)));
  endtask

  // Sender: bursts of random length, random gaps between them.
  // Entered at a falling edge, returns at the falling edge after the beat.
  task automatic send_byte(input logic [7:0] d, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        in_data_i  <= in_t'(9'($urandom));
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: d, last_byte: l};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Mostly runs of the search pattern, partly pattern bytes out of place,
  // partly noise.
  function automatic logic [7:0] stream_byte();
    logic [7:0]  b;
    int unsigned k;
    case ($urandom_range(0, 3))
      0: b = 8'($urandom);
      1, 2: begin
        b     = cur_sp[run_k*8 +: 8];
        run_k = (run_k + 1) % cur_sl;
      end
      default: begin
        k = $urandom_range(0, cur_sl - 1);
        b = cur_sp[k*8 +: 8];
      end
    endcase
    return b;
  endfunction

  task automatic send_stream(input int unsigned len);
    run_k = 0;
    for (int unsigned n = 0; n < len; n++) send_byte(stream_byte(), n == len - 1);
    rand_items += len;
  endtask

  function automatic int unsigned rand_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(1, 8);
    if (r < 9) return $urandom_range(9, 30);
    return $urandom_range(31, 64);
  endfunction

  // Drop valid, wait for every expected beat, then let the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (WB + 4) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned ns;
    burst_left = 0;
    rand_items = 0;
    cur_sp     = '0;
    cur_sl     = 1;
    run_k      = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: search byte 00, nothing replaced; then a one-byte buffer
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b1);
    settle();

    // repeated "AB" whose first hit's replacement, longer than the search and
    // clipped at the end, overwrites the rest; a short tail on the final byte
    apply_cfg(64'h4241, 4'd2, 64'h5858, 4'd8, 16'd0, 1'b0);
    for (int i = 0; i < 5; i++) send_byte((i % 2) ? 8'h42 : 8'h41, i == 4);
    settle();

    // search length zero reads as one, replace length saturates, limit of one
    apply_cfg('1, 4'd0, 64'h0123456789ABCDEF, 4'd15, 16'd1, 1'b0);
    for (int i = 0; i < 9; i++) send_byte(8'hFF, i == 8);
    settle();

    // search length saturates at eight; the only hit is the very last
    // position where the whole pattern fits, at offset one
    apply_cfg(64'h0706050403020100, 4'd15, 64'hF0E1D2C3B4A59687, 4'd8, 16'hFFFF, 1'b1);
    send_byte(8'h55, 1'b0);
    for (int i = 0; i < 8; i++) send_byte(i[7:0], i == 7);
    settle();

    // back-pressure: receiver holds off while the sender keeps offering
    rand_cfg();
    pressure_go <= 1'b1;
    send_stream(48);
    settle();

    while (rand_items < RAND_ITEMS) begin
      rand_cfg();
      ns = $urandom_range(1, 4);
      repeat (ns) send_stream(rand_len());
      settle();
    end

    if (err_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
